// ===== src/tmas_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmas_pkg
// Shared types, codes and the sigmoid lookup table of the anomaly scorer.
// ----------------------------------------------------------------------------
package tmas_pkg;

   localparam int NUM_FEATURES = 3;
   localparam int NUM_HIDDEN   = 8;
   localparam int PARAM_WORDS  = NUM_FEATURES * NUM_HIDDEN + 2 * NUM_HIDDEN;
   localparam int BIAS_BASE    = NUM_FEATURES * NUM_HIDDEN;
   localparam int OUTW_BASE    = NUM_FEATURES * NUM_HIDDEN + NUM_HIDDEN;
   localparam int ADDR_W       = $clog2(PARAM_WORDS);
   localparam int HID_W        = $clog2(NUM_HIDDEN);
   localparam int SIG_ENTRIES  = 256;
   localparam int SIG_SPAN     = SIG_ENTRIES - 1;

   // z clamp bound, 30 in Q.36
   localparam logic [63:0] Z_LIMIT = 64'd30 << 36;
   // floor(n / 60) as (n * RECIP_60) >> RECIP_SHIFT, exact for n below 23831
   localparam logic [14:0] RECIP_60    = 15'd17477;
   localparam int          RECIP_SHIFT = 20;

   // function codes
   localparam logic [1:0] FUNC_WRITE = 2'd0;
   localparam logic [1:0] FUNC_INFER = 2'd1;
   localparam logic [1:0] FUNC_LOAD  = 2'd2;

   // status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_MODEL = 2'd1;
   localparam logic [1:0] STAT_NO_INPUT = 2'd2;
   localparam logic [1:0] STAT_RANGE    = 2'd3;

   // register indexes
   localparam logic [2:0] REG_FALLBACK = 3'd0;
   localparam logic [2:0] REG_LIMIT    = 3'd1;
   localparam logic [2:0] REG_SCALE_A  = 3'd2;
   localparam logic [2:0] REG_SCALE_B  = 3'd3;
   localparam logic [2:0] REG_SCALE_C  = 3'd4;
   localparam logic [2:0] REG_CHECK    = 3'd5;

   typedef struct packed {
      logic                          en;
      logic [ADDR_W-1:0]             addr;
      logic [15:0]                   data;
   } wr_type;

   typedef struct packed {
      logic                          start;
      logic                          ack;
      logic [NUM_FEATURES-1:0][15:0] feat;
      logic [NUM_FEATURES-1:0][15:0] scale;
   } job_type;

   typedef struct packed {
      logic                          done;
      logic                          busy;
      logic [15:0]                   score;
   } res_type;

   typedef logic [15:0] sig_table_type [SIG_ENTRIES];

   // restoring long division, only used while building the table
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] dvs);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, dvs}) begin
            rem  = rem - {1'b0, dvs};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // e^-t, t and result in Q.32
   function automatic logic [63:0] exp_neg_q32(logic [63:0] t);
      logic [63:0] ip;
      logic [63:0] f;
      logic [63:0] r;
      logic [63:0] term;
      longint      sum;
      ip   = t >> 32;
      f    = t & 64'hFFFF_FFFF;
      r    = 64'd1 << 32;
      term = 64'd1 << 32;
      sum  = longint'(64'd1 << 32);
      for (int n = 1; n <= 20; n++) begin
         term = udiv64((term * f) >> 32, 64'(n));
         if ((n & 1) == 1) sum = sum - longint'(term);
         else sum = sum + longint'(term);
      end
      for (int i = 0; i < 64; i++) begin
         if (64'(i) < ip) r = (r * 64'd1580030169) >> 32;
      end
      if (sum < 0) sum = 0;
      return (r * 64'(sum)) >> 32;
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      longint        num;
      logic [63:0]   mag;
      logic [63:0]   e;
      logic [63:0]   den;
      logic [63:0]   v;
      for (int k = 0; k < SIG_ENTRIES; k++) begin
         num = 60 * longint'(k) - 30 * longint'(SIG_SPAN);
         mag = (num < 0) ? 64'(-num) : 64'(num);
         e   = exp_neg_q32(udiv64(mag << 32, 64'(SIG_SPAN)));
         den = (64'd1 << 32) + e;
         if (num >= 0) v = udiv64((64'd1 << 48) + (den >> 1), den);
         else v = udiv64((e << 16) + (den >> 1), den);
         tbl[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== src/tmas_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmas_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tmas_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 40
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/tmas_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmas_core
// Inference engine: parameter memory, feature scaling, multiply-accumulate
// stepping through the stored words, z clamp, table index and sigmoid lookup.
// ----------------------------------------------------------------------------
module tmas_core (
   input  logic             clock,
   input  logic             reset,
   input  tmas_pkg::wr_type  wr,
   input  tmas_pkg::job_type job,
   output tmas_pkg::res_type res
);

   typedef enum logic [6:0] {
      C_IDLE  = 7'b0000001,
      C_SCALE = 7'b0000010,
      C_RUN   = 7'b0000100,
      C_TAIL  = 7'b0001000,
      C_CLAMP = 7'b0010000,
      C_DIV   = 7'b0100000,
      C_LOOK  = 7'b1000000
   } cstate_type;

   cstate_type state_ff, state_in;
   logic       done_ff, done_in;

   logic [1:0]                   fcnt_ff, fcnt_in;
   logic signed [23:0]           s_ff [tmas_pkg::NUM_FEATURES];
   logic [tmas_pkg::HID_W-1:0]   neuron_ff, neuron_in;
   logic [2:0]                   phase_ff, phase_in;
   logic                         rd_valid_ff, rd_last_ff;
   logic [2:0]                   rd_phase_ff;
   logic signed [41:0]           acc_ff, acc_in;
   logic signed [63:0]           z_ff, z_in;
   logic [13:0]                  n_ff;
   logic [7:0]                   k_ff;
   logic [15:0]                  score_ff;

   logic [tmas_pkg::ADDR_W-1:0]  rd_addr;
   logic [15:0]                  rd_data;
   logic                         last_issue;
   logic signed [31:0]           scale_prod;
   logic signed [39:0]           mac_prod;
   logic signed [57:0]           out_prod;
   logic signed [63:0]           z_clamped;
   logic [63:0]                  off;
   logic [63:0]                  idx_num;
   logic [28:0]                  div_prod;
   logic [8:0]                   quot;

   tmas_ram #(
      .WIDTH (16),
      .DEPTH (tmas_pkg::PARAM_WORDS)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (state_ff == C_RUN),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // word order per neuron: bias, three layer-one weights, output weight
   always_comb begin
      case (phase_ff)
         3'd0: rd_addr = tmas_pkg::ADDR_W'(tmas_pkg::BIAS_BASE)
                       + tmas_pkg::ADDR_W'(neuron_ff);
         3'd4: rd_addr = tmas_pkg::ADDR_W'(tmas_pkg::OUTW_BASE)
                       + tmas_pkg::ADDR_W'(neuron_ff);
         default: rd_addr = tmas_pkg::ADDR_W'({phase_ff[1:0] - 2'd1, neuron_ff});
      endcase
   end

   assign last_issue = (neuron_ff == tmas_pkg::HID_W'(tmas_pkg::NUM_HIDDEN - 1))
                       && (phase_ff == 3'd4);
   assign scale_prod = $signed(job.scale[fcnt_ff]) * $signed(job.feat[fcnt_ff]);
   assign mac_prod   = s_ff[rd_phase_ff[1:0] - 2'd1] * $signed(rd_data);
   assign out_prod   = acc_ff * $signed(rd_data);

   always_comb begin
      if (z_ff > $signed(tmas_pkg::Z_LIMIT)) z_clamped = $signed(tmas_pkg::Z_LIMIT);
      else if (z_ff < -$signed(tmas_pkg::Z_LIMIT)) z_clamped = -$signed(tmas_pkg::Z_LIMIT);
      else z_clamped = z_ff;
      off      = unsigned'(z_clamped) + tmas_pkg::Z_LIMIT;
      idx_num  = off * 64'd255 + tmas_pkg::Z_LIMIT;
      div_prod = 29'(n_ff) * 29'(tmas_pkg::RECIP_60);
      quot     = div_prod[28:tmas_pkg::RECIP_SHIFT];
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      fcnt_in   = fcnt_ff;
      neuron_in = neuron_ff;
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      z_in      = z_ff;
      case (state_ff)
         C_IDLE: begin
            if (done_ff && job.ack) done_in = 1'b0;
            if (job.start) begin
               state_in  = C_SCALE;
               fcnt_in   = 2'd0;
               neuron_in = '0;
               phase_in  = 3'd0;
               z_in      = '0;
            end
         end
         C_SCALE: begin
            fcnt_in = fcnt_ff + 2'd1;
            if (fcnt_ff == 2'(tmas_pkg::NUM_FEATURES - 1)) state_in = C_RUN;
         end
         C_RUN: begin
            if (phase_ff == 3'd4) begin
               phase_in  = 3'd0;
               neuron_in = neuron_ff + 1'b1;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
            if (last_issue) state_in = C_TAIL;
         end
         C_TAIL:  state_in = C_CLAMP;
         C_CLAMP: state_in = C_DIV;
         C_DIV:   state_in = C_LOOK;
         C_LOOK: begin
            state_in = C_IDLE;
            done_in  = 1'b1;
         end
         default: state_in = C_IDLE;
      endcase
      if (rd_valid_ff) begin
         case (rd_phase_ff)
            3'd0: acc_in = 42'(signed'(rd_data)) <<< 12;
            3'd4: if (acc_ff > 0) z_in = z_ff + 64'(out_prod);
            default: acc_in = acc_ff + 42'(mac_prod);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= C_IDLE;
         done_ff     <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         done_ff     <= done_in;
         rd_valid_ff <= (state_ff == C_RUN);
      end
      fcnt_ff     <= fcnt_in;
      neuron_ff   <= neuron_in;
      phase_ff    <= phase_in;
      rd_phase_ff <= phase_ff;
      rd_last_ff  <= last_issue;
      acc_ff      <= acc_in;
      z_ff        <= z_in;
      if (state_ff == C_SCALE) s_ff[fcnt_ff] <= scale_prod[31:8];
      if (state_ff == C_CLAMP) n_ff <= idx_num[49:36];
      if (state_ff == C_DIV) k_ff <= (quot > 9'd255) ? 8'd255 : quot[7:0];
      if (state_ff == C_LOOK) score_ff <= tmas_pkg::SIG_TABLE[k_ff];
   end

   assign res.done  = done_ff;
   assign res.busy  = (state_ff != C_IDLE) || rd_last_ff;
   assign res.score = score_ff;

endmodule

// ===== src/tiny_mlp_anomaly_scorer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_mlp_anomaly_scorer
// Three-feature, eight-neuron MLP anomaly scorer with checks and fallback.
// ----------------------------------------------------------------------------
// Parameter writes, load marks, unknown function codes and failed inferences
// give their word in the cycle after acceptance. A passing inference runs from
// acceptance to the result word through feature scaling, then 40 reads through
// the one read port of the parameter memory feeding the multiply-accumulate, a
// wait for the last read to land, clamp, index, table lookup and the hand-over
// to the output register, once it is free. One item is worked on at a time; the
// next is taken once the output register is empty or being read in the same cycle.
module tiny_mlp_anomaly_scorer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // feature_a, feature_b, feature_c, feature_valid, param_index, param_value
   input  logic [79:0] req_tdata,
   // func
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // score, fallback_total
   output logic [47:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [1:0] {
      T_IDLE = 2'b01,
      T_BUSY = 2'b10
   } tstate_type;

   tstate_type state_ff, state_in;

   logic [15:0] fallback_ff;
   logic [14:0] limit_ff;
   logic [15:0] scale_ff [tmas_pkg::NUM_FEATURES];
   logic        check_ff;
   logic        model_ready_ff;
   logic [31:0] fail_cnt_ff, fail_cnt_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_score_ff, out_score_in;
   logic [1:0]  out_status_ff, out_status_in;
   logic [tmas_pkg::NUM_FEATURES-1:0][15:0] feat_ff;

   logic [1:0]  func;
   logic [2:0]  feat_valid;
   logic [5:0]  param_index;
   logic [15:0] param_value;
   logic [tmas_pkg::NUM_FEATURES-1:0][15:0] feat;
   logic        accept;
   logic        slot_free;
   logic        csr_wr;
   logic [1:0]  chk_status;
   logic [16:0] mag;

   tmas_pkg::wr_type  wr;
   tmas_pkg::job_type job;
   tmas_pkg::res_type res;

   assign func        = req_tuser;
   assign feat[0]     = req_tdata[15:0];
   assign feat[1]     = req_tdata[31:16];
   assign feat[2]     = req_tdata[47:32];
   assign feat_valid  = req_tdata[50:48];
   assign param_index = req_tdata[56:51];
   assign param_value = req_tdata[72:57];

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == T_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         fallback_ff <= '0;
         limit_ff    <= 15'h7FFF;
         scale_ff[0] <= 16'd4096;
         scale_ff[1] <= 16'd4096;
         scale_ff[2] <= 16'd4096;
         check_ff    <= 1'b1;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            tmas_pkg::REG_FALLBACK: fallback_ff <= csr_pwdata[15:0];
            tmas_pkg::REG_LIMIT:    limit_ff    <= csr_pwdata[14:0];
            tmas_pkg::REG_SCALE_A:  scale_ff[0] <= csr_pwdata[15:0];
            tmas_pkg::REG_SCALE_B:  scale_ff[1] <= csr_pwdata[15:0];
            tmas_pkg::REG_SCALE_C:  scale_ff[2] <= csr_pwdata[15:0];
            tmas_pkg::REG_CHECK:    check_ff    <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         tmas_pkg::REG_FALLBACK: csr_prdata = {16'd0, fallback_ff};
         tmas_pkg::REG_LIMIT:    csr_prdata = {17'd0, limit_ff};
         tmas_pkg::REG_SCALE_A:  csr_prdata = {{16{scale_ff[0][15]}}, scale_ff[0]};
         tmas_pkg::REG_SCALE_B:  csr_prdata = {{16{scale_ff[1][15]}}, scale_ff[1]};
         tmas_pkg::REG_SCALE_C:  csr_prdata = {{16{scale_ff[2][15]}}, scale_ff[2]};
         tmas_pkg::REG_CHECK:    csr_prdata = {31'd0, check_ff};
         default:                csr_prdata = '0;
      endcase
   end

   // checks: model first, then, if enabled, per feature missing before out of range
   always_comb begin
      chk_status = tmas_pkg::STAT_OK;
      mag        = '0;
      if (!model_ready_ff) begin
         chk_status = tmas_pkg::STAT_NO_MODEL;
      end else if (check_ff) begin
         for (int i = tmas_pkg::NUM_FEATURES - 1; i >= 0; i--) begin
            mag = feat[i][15] ? 17'(-$signed({1'b1, feat[i]})) : {1'b0, feat[i]};
            if (!feat_valid[i]) chk_status = tmas_pkg::STAT_NO_INPUT;
            else if (mag > {2'b00, limit_ff}) chk_status = tmas_pkg::STAT_RANGE;
         end
      end
   end

   assign wr.en   = accept && (func == tmas_pkg::FUNC_WRITE)
                    && (param_index < 6'(tmas_pkg::PARAM_WORDS));
   assign wr.addr = param_index[tmas_pkg::ADDR_W-1:0];
   assign wr.data = param_value;

   assign job.start = accept && (func == tmas_pkg::FUNC_INFER)
                      && (chk_status == tmas_pkg::STAT_OK);
   assign job.ack   = (state_ff == T_BUSY) && res.done && slot_free;
   assign job.feat  = feat_ff;
   assign job.scale = {scale_ff[2], scale_ff[1], scale_ff[0]};

   tmas_core u_core (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .job   (job),
      .res   (res)
   );

   always_comb begin
      state_in      = state_ff;
      fail_cnt_in   = fail_cnt_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_score_in  = out_score_ff;
      out_status_in = out_status_ff;
      case (state_ff)
         T_IDLE: begin
            if (job.start) begin
               state_in = T_BUSY;
            end else if (accept) begin
               out_valid_in  = 1'b1;
               out_score_in  = '0;
               out_status_in = tmas_pkg::STAT_OK;
               if (func == tmas_pkg::FUNC_INFER) begin
                  out_score_in  = fallback_ff;
                  out_status_in = chk_status;
                  if (fail_cnt_ff != 32'hFFFF_FFFF) fail_cnt_in = fail_cnt_ff + 32'd1;
               end
            end
         end
         T_BUSY: begin
            if (job.ack) begin
               state_in      = T_IDLE;
               out_valid_in  = 1'b1;
               out_score_in  = res.score;
               out_status_in = tmas_pkg::STAT_OK;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= T_IDLE;
         model_ready_ff <= 1'b0;
         fail_cnt_ff    <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fail_cnt_ff  <= fail_cnt_in;
         out_valid_ff <= out_valid_in;
         if (accept && (func == tmas_pkg::FUNC_LOAD)) model_ready_ff <= 1'b1;
      end
      out_score_ff  <= out_score_in;
      out_status_ff <= out_status_in;
      if (accept) feat_ff <= feat;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {fail_cnt_ff, out_score_ff};
   assign rsp_tuser  = out_status_ff;

   // the core only runs while the front end waits on it
   a_core_owned: assert property (@(posedge clock) disable iff (reset)
      res.busy |-> (state_ff == T_BUSY))
      else $error("core active outside busy state");

   // the failure count never goes down
   a_count_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (fail_cnt_ff >= $past(fail_cnt_ff)))
      else $error("failure count decreased");

   // a missing model result can only appear while no model is marked
   a_no_model: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (out_status_ff == tmas_pkg::STAT_NO_MODEL)) |-> !model_ready_ff)
      else $error("model-missing status with model loaded");

   // a started inference always takes the front end to the busy state, never to a direct result load
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      job.start |=> (state_ff == T_BUSY))
      else $error("inference start lost");

endmodule

// ===== tb/sv/tb_tiny_mlp_anomaly_scorer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tiny_mlp_anomaly_scorer
// Self-checking bench for the MLP anomaly scorer. Parameter words are loaded,
// then load marks, inferences, writes and unknown codes go in random bursts
// over several register settings. A scoreboard predicts every result word.
// ----------------------------------------------------------------------------
module tb_tiny_mlp_anomaly_scorer;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int PHASES = 8;

   typedef struct {
      logic [15:0] score;
      logic [1:0]  status;
      logic [31:0] total;
   } score_word_type;

   class score_board_type;
      logic [15:0]        weights [tmas_pkg::PARAM_WORDS];
      bit                 loaded;
      logic [31:0]        fails;
      logic [15:0]        fallback;
      logic [14:0]        limit;
      logic signed [15:0] scale [tmas_pkg::NUM_FEATURES];
      bit                 check_en;
      logic [15:0]        sig [256];
      score_word_type     pending_q [$];
      int                 errors;

      function new();
         longint      num;
         logic [63:0] mag, e, den, v;
         for (int k = 0; k < 256; k++) begin
            num = 60 * longint'(k) - 30 * 255;
            mag = (num < 0) ? 64'(-num) : 64'(num);
            e   = exp_neg((mag << 32) / 64'd255);
            den = (64'd1 << 32) + e;
            if (num >= 0) v = ((64'd1 << 48) + den / 2) / den;
            else v = ((e << 16) + den / 2) / den;
            sig[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
         end
         loaded   = 0;
         fails    = 0;
         fallback = 0;
         limit    = 15'h7FFF;
         for (int i = 0; i < tmas_pkg::NUM_FEATURES; i++) scale[i] = 16'sd4096;
         check_en = 1;
         errors   = 0;
      endfunction

      // e^-t, Q.32 in and out, truncated series plus whole-part steps
      function logic [63:0] exp_neg(logic [63:0] t);
         logic [63:0] ip, f, r, term;
         longint      acc;
         ip   = t >> 32;
         f    = t & 64'hFFFF_FFFF;
         r    = 64'd1 << 32;
         term = 64'd1 << 32;
         acc  = longint'(64'd1 << 32);
         for (int n = 1; n <= 20; n++) begin
            term = ((term * f) >> 32) / 64'(n);
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
         end
         while (ip > 0) begin
            r  = (r * 64'd1580030169) >> 32;
            ip = ip - 1;
         end
         if (acc < 0) acc = 0;
         return (r * 64'(acc)) >> 32;
      endfunction

      function logic [15:0] mlp_score(longint x [tmas_pkg::NUM_FEATURES]);
         longint s [tmas_pkg::NUM_FEATURES];
         longint z, acc, zl, off, k;
         zl = longint'(30) << 36;
         z  = 0;
         for (int i = 0; i < tmas_pkg::NUM_FEATURES; i++)
            s[i] = (longint'(scale[i]) * x[i]) >>> 8;
         for (int j = 0; j < tmas_pkg::NUM_HIDDEN; j++) begin
            acc = longint'($signed(weights[tmas_pkg::BIAS_BASE + j])) * 4096;
            for (int i = 0; i < tmas_pkg::NUM_FEATURES; i++)
               acc += s[i] * longint'($signed(weights[i * tmas_pkg::NUM_HIDDEN + j]));
            if (acc > 0) z += acc * longint'($signed(weights[tmas_pkg::OUTW_BASE + j]));
         end
         if (z > zl) z = zl;
         if (z < -zl) z = -zl;
         off = z + zl;
         k = (off * 255 + zl) / (2 * zl);
         if (k > 255) k = 255;
         return sig[k];
      endfunction

      function void note_word(logic [1:0] func, logic [15:0] fa, logic [15:0] fb,
                              logic [15:0] fc, logic [2:0] valid, logic [5:0] idx,
                              logic [15:0] val);
         score_word_type w;
         longint         x [tmas_pkg::NUM_FEATURES];
         longint         a;
         w.score  = 0;
         w.status = tmas_pkg::STAT_OK;
         if (func == tmas_pkg::FUNC_WRITE) begin
            if (idx < tmas_pkg::PARAM_WORDS) weights[idx] = val;
         end else if (func == tmas_pkg::FUNC_LOAD) begin
            loaded = 1;
         end else if (func == tmas_pkg::FUNC_INFER) begin
            x[0] = $signed(fa);
            x[1] = $signed(fb);
            x[2] = $signed(fc);
            if (!loaded) w.status = tmas_pkg::STAT_NO_MODEL;
            else if (check_en) begin
               for (int i = 0; i < tmas_pkg::NUM_FEATURES && w.status == tmas_pkg::STAT_OK;
                    i++) begin
                  a = (x[i] < 0) ? -x[i] : x[i];
                  if (!valid[i]) w.status = tmas_pkg::STAT_NO_INPUT;
                  else if (a > longint'(limit)) w.status = tmas_pkg::STAT_RANGE;
               end
            end
            if (w.status != tmas_pkg::STAT_OK) begin
               w.score = fallback;
               if (fails != 32'hFFFF_FFFF) fails++;
            end else begin
               w.score = mlp_score(x);
            end
         end
         w.total = fails;
         pending_q = {pending_q, w};
      endfunction

      function void check_word(logic [15:0] score, logic [1:0] status, logic [31:0] total);
         score_word_type w;
         if (pending_q.size() == 0) begin
            $error("result word with nothing expected");
            errors++;
            return;
         end
         w = pending_q.pop_front();
         if (score !== w.score) begin
            $error("score: expected %0d, got %0d", w.score, score);
            errors++;
         end
         if (status !== w.status) begin
            $error("status: expected %0d, got %0d", w.status, status);
            errors++;
         end
         if (total !== w.total) begin
            $error("fallback_total: expected %0d, got %0d", w.total, total);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   score_board_type sb;
   int unsigned     cycles;
   int unsigned     stall_tick;
   int              burst_left;

   tiny_mlp_anomaly_scorer dut (.*);

   initial clock = 0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_tiny_mlp_anomaly_scorer: FAIL");
         $finish;
      end
   end

   // receiver: free-running stretches, a full stall, then random back-pressure
   always @(posedge clock) begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 300 < 100) rsp_tready <= 1'b1;
      else if (stall_tick % 300 < 110) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_word(rsp_tdata[15:0], rsp_tuser, rsp_tdata[47:16]);
   end

   task automatic send_word(logic [1:0] func, logic [15:0] fa, logic [15:0] fb,
                            logic [15:0] fc, logic [2:0] valid, logic [5:0] idx,
                            logic [15:0] val);
      req_tdata  <= {7'd0, val, idx, valid, fc, fb, fa};
      req_tuser  <= func;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_word(func, fa, fb, fc, valid, idx, val);
      // bursts of random length, random gaps between them
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 20);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         tmas_pkg::REG_FALLBACK: sb.fallback = val[15:0];
         tmas_pkg::REG_LIMIT:    sb.limit = val[14:0];
         tmas_pkg::REG_SCALE_A:  sb.scale[0] = val[15:0];
         tmas_pkg::REG_SCALE_B:  sb.scale[1] = val[15:0];
         tmas_pkg::REG_SCALE_C:  sb.scale[2] = val[15:0];
         tmas_pkg::REG_CHECK:    sb.check_en = val[0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_param();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($signed(17'($urandom_range(0, 2048))) - 17'sd1024);
   endfunction

   function automatic logic [15:0] rand_feature();
      int m, lim;
      m   = $urandom_range(0, 9);
      lim = (sb.limit < 1024) ? sb.limit : 1024;
      case (m)
         0: case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'(sb.limit);
               3: return 16'(-int'(sb.limit));
               default: return 16'(int'(sb.limit) + 1);
            endcase
         1, 2: return 16'($urandom);
         default: return 16'(int'($urandom_range(0, 2 * lim)) - lim);
      endcase
   endfunction

   task automatic rand_item();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) send_word(tmas_pkg::FUNC_WRITE, 16'($urandom), 16'($urandom),
                           16'($urandom), 3'($urandom),
                           6'($urandom_range(0, tmas_pkg::PARAM_WORDS - 1)),
                           rand_param());
      else if (r < 10) send_word(tmas_pkg::FUNC_WRITE, 0, 0, 0, 0,
                                 6'($urandom_range(tmas_pkg::PARAM_WORDS, 63)),
                                 16'($urandom));
      else if (r < 12) send_word(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
                                 3'($urandom), 6'($urandom), 16'($urandom));
      else if (r < 14) send_word(tmas_pkg::FUNC_LOAD, 0, 0, 0, 3'($urandom),
                                 6'($urandom), 0);
      else send_word(tmas_pkg::FUNC_INFER, rand_feature(), rand_feature(), rand_feature(),
                     ($urandom_range(0, 9) == 0) ? 3'($urandom) : 3'b111,
                     6'($urandom), 16'($urandom));
   endtask

   task automatic set_phase(int p);
      case (p)
         0: begin
            csr_write(tmas_pkg::REG_FALLBACK, 0);
            csr_write(tmas_pkg::REG_LIMIT, 32'h7FFF);
            csr_write(tmas_pkg::REG_SCALE_A, 4096);
            csr_write(tmas_pkg::REG_SCALE_B, 4096);
            csr_write(tmas_pkg::REG_SCALE_C, 4096);
            csr_write(tmas_pkg::REG_CHECK, 1);
         end
         1: begin
            csr_write(tmas_pkg::REG_FALLBACK, 32'hFFFF);
            csr_write(tmas_pkg::REG_LIMIT, 0);
            csr_write(tmas_pkg::REG_SCALE_A, 32'h8000);
            csr_write(tmas_pkg::REG_SCALE_B, 32'h8000);
            csr_write(tmas_pkg::REG_SCALE_C, 32'h8000);
         end
         2: begin
            csr_write(tmas_pkg::REG_FALLBACK, 0);
            csr_write(tmas_pkg::REG_LIMIT, 32'h7FFF);
            csr_write(tmas_pkg::REG_SCALE_A, 32'h7FFF);
            csr_write(tmas_pkg::REG_SCALE_B, 32'h7FFF);
            csr_write(tmas_pkg::REG_SCALE_C, 32'h7FFF);
            csr_write(tmas_pkg::REG_CHECK, 0);
         end
         default: begin
            csr_write(tmas_pkg::REG_FALLBACK, $urandom_range(0, 65535));
            csr_write(tmas_pkg::REG_LIMIT, ($urandom_range(0, 3) == 0)
                                           ? $urandom_range(0, 32767)
                                           : $urandom_range(256, 2048));
            csr_write(tmas_pkg::REG_SCALE_A,
                      32'($signed(17'($urandom_range(0, 16384))) - 17'sd8192));
            csr_write(tmas_pkg::REG_SCALE_B,
                      32'($signed(17'($urandom_range(0, 16384))) - 17'sd8192));
            csr_write(tmas_pkg::REG_SCALE_C, ($urandom_range(0, 3) == 0) ? $urandom
                                             : 32'($urandom_range(0, 8192)));
            csr_write(tmas_pkg::REG_CHECK, $urandom_range(0, 3) != 0);
         end
      endcase
   endtask

   initial begin
      sb          = new();
      cycles      = 0;
      stall_tick  = 0;
      burst_left  = 0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = tmas_pkg::FUNC_WRITE;
      rsp_tready  = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: no model yet, full load, stray write and unknown code, then load marks and edge-case inferences
      send_word(tmas_pkg::FUNC_INFER, 16'h0100, 16'h0100, 16'h0100, 3'b111, 0, 0);
      for (int i = 0; i < tmas_pkg::PARAM_WORDS; i++)
         send_word(tmas_pkg::FUNC_WRITE, 0, 0, 0, 0, 6'(i),
                   (i == 0) ? 16'h8000 : (i == 1) ? 16'h7FFF : rand_param());
      send_word(tmas_pkg::FUNC_WRITE, 0, 0, 0, 0, 6'd63, 16'hFFFF);
      send_word(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'b111, 6'd63, 16'hFFFF);
      send_word(tmas_pkg::FUNC_INFER, 0, 0, 0, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0);
      send_word(tmas_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 0, 0, 0, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h0200, 16'hFE00, 16'h0080, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h0100, 16'h0100, 16'h0100, 3'b110, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h0100, 16'h0100, 16'h0100, 3'b101, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h0100, 16'h0100, 16'h0100, 3'b011, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h8000, 16'h7FFF, 16'h0000, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h8001, 16'h8001, 16'h8001, 3'b111, 0, 0);
      send_word(tmas_pkg::FUNC_INFER, 16'h0000, 16'h8000, 16'h0000, 3'b000, 0, 0);

      for (int p = 0; p < PHASES; p++) begin
         req_tvalid <= 1'b0;
         wait_idle();
         set_phase(p);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) rand_item();
      end
      req_tvalid <= 1'b0;
      wait_idle();
      repeat (60) @(posedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("tb_tiny_mlp_anomaly_scorer: PASS");
      else
         $display("tb_tiny_mlp_anomaly_scorer: FAIL");
      $finish;
   end

endmodule
